### rtl/tle_pkg.sv
// tle_pkg: shared types, codes and constants for the terminal line editor.
// No dependencies; used by tle_ctrl, tle_emit and terminal_line_editor.
`default_nettype none

package tle_pkg;

    localparam int BUFFER_BYTES_DEF = 256;
    localparam int MAX_RESULTS      = 8;
    localparam int CNT_W            = 4;
    localparam int STEP_W           = 3;

    // request codes
    localparam logic [1:0] REQ_KEY  = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_LINE = 2'd1;
    localparam logic [1:0] KIND_NONE = 2'd2;

    // configuration register indexes
    localparam logic CFG_BLINK = 1'b0;
    localparam logic CFG_TAB   = 1'b1;

    localparam logic [7:0] BLINK_RESET = 8'd5;
    localparam logic [3:0] TAB_RESET   = 4'd4;
    localparam logic [3:0] TAB_MAX     = 4'd8;
    localparam logic [7:0] IDLE_MAX    = 8'hFF;

    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_BAR = 8'h7C;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_STORE,
        OP_TAB,
        OP_BKSP,
        OP_GLYPH,
        OP_READ
    } t_op;

    // one burst of results handed from control to the result sequencer
    typedef struct packed {
        t_op              op;
        logic [CNT_W-1:0] cnt;
        logic [7:0]       data;
        logic             lr;
    } t_burst;

    // erase sequence: space, backspace, backspace, space, backspace
    function automatic logic [7:0] bksp_byte(input logic [STEP_W-1:0] step);
        logic [7:0] b;
        case (step)
            3'd0:    b = CH_SP;
            3'd3:    b = CH_SP;
            default: b = CH_BS;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

### rtl/tle_line_mem.sv
// tle_line_mem: line store, one write port and one registered read port.
// Same-cycle write/read of one address forwards the write data. Uses no package.
`default_nettype none

module tle_line_mem #(
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [7:0]    o_rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= (i_we && (i_waddr == i_raddr)) ? i_wdata : mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

### rtl/tle_ctrl.sv
// tle_ctrl: configuration registers, line/cursor state and request decode.
// Depends on tle_pkg; feeds tle_emit with one burst per accepted item.
`default_nettype none

module tle_ctrl #(
    parameter int BUFFER_BYTES = tle_pkg::BUFFER_BYTES_DEF,
    localparam int AW = $clog2(BUFFER_BYTES),
    localparam int LW = $clog2(BUFFER_BYTES + 1)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire logic [1:0]      i_req_type,
    input  wire logic [7:0]      i_key_byte,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_index,
    input  wire logic [7:0]      i_cfg_data,
    input  wire logic            i_gen_free,
    output logic                 o_load,
    output tle_pkg::t_burst      o_burst,
    output logic      [AW-1:0]   o_wr_base,
    output logic                 o_rd_en,
    output logic      [AW-1:0]   o_rd_addr
);

    localparam logic [LW-1:0] LIMIT = LW'(BUFFER_BYTES - 1);

    logic [7:0]    r_bp;
    logic [3:0]    r_tw;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_rp,  n_rp;
    logic          r_complete, n_complete;
    logic [7:0]    r_idle, n_idle;
    logic          r_cursor, n_cursor;

    logic            accept;
    logic            rd_op;
    logic [3:0]      tab_w;
    logic [LW-1:0]   room;
    logic [3:0]      tab_n;
    logic [LW-1:0]   rp_inc;
    tle_pkg::t_burst burst;

    assign accept     = i_in_valid && i_gen_free;
    assign o_in_stall = !i_gen_free;

    // tab spaces: min(tab_width, 8), cut at the text limit
    assign tab_w  = (r_tw > tle_pkg::TAB_MAX) ? tle_pkg::TAB_MAX : r_tw;
    assign room   = LIMIT - r_len;
    assign tab_n  = (room < LW'(tab_w)) ? room[3:0] : tab_w;
    assign rp_inc = r_rp + LW'(1);

    always_comb begin
        n_len      = r_len;
        n_rp       = r_rp;
        n_complete = r_complete;
        n_idle     = r_idle;
        n_cursor   = r_cursor;
        rd_op      = 1'b0;
        burst.op   = tle_pkg::OP_NONE;
        burst.cnt  = tle_pkg::CNT_W'(1);
        burst.data = 8'd0;
        unique case (i_req_type)
            tle_pkg::REQ_KEY: begin
                if (!r_complete) begin
                    if (i_key_byte == tle_pkg::CH_LF) begin
                        burst.op   = tle_pkg::OP_STORE;
                        burst.data = tle_pkg::CH_LF;
                        n_len      = r_len + LW'(1);
                        n_complete = 1'b1;
                    end else if (i_key_byte == tle_pkg::CH_BS) begin
                        if (r_len != '0) begin
                            burst.op  = tle_pkg::OP_BKSP;
                            burst.cnt = tle_pkg::CNT_W'(5);
                            n_len     = r_len - LW'(1);
                        end
                    end else if (i_key_byte == tle_pkg::CH_TAB) begin
                        if (tab_n != 4'd0) begin
                            burst.op   = tle_pkg::OP_TAB;
                            burst.cnt  = tab_n;
                            burst.data = tle_pkg::CH_SP;
                            n_len      = r_len + LW'(tab_n);
                        end
                    end else if (r_len < LIMIT) begin
                        burst.op   = tle_pkg::OP_STORE;
                        burst.data = i_key_byte;
                        n_len      = r_len + LW'(1);
                    end
                end
            end
            tle_pkg::REQ_TICK: begin
                if (!r_complete) begin
                    if (r_idle > r_bp) begin
                        n_cursor   = !r_cursor;
                        burst.op   = tle_pkg::OP_GLYPH;
                        burst.cnt  = tle_pkg::CNT_W'(2);
                        burst.data = !r_cursor ? tle_pkg::CH_BAR : tle_pkg::CH_SP;
                        n_idle     = 8'd0;
                    end else if (r_idle != tle_pkg::IDLE_MAX) begin
                        n_idle = r_idle + 8'd1;
                    end
                end
            end
            tle_pkg::REQ_READ: begin
                if (r_complete) begin
                    rd_op    = 1'b1;
                    burst.op = tle_pkg::OP_READ;
                    n_rp     = rp_inc;
                    // last byte drained: reopen editing
                    if (rp_inc >= r_len) begin
                        n_len      = '0;
                        n_rp       = '0;
                        n_complete = 1'b0;
                        n_idle     = 8'd0;
                        n_cursor   = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        burst.lr = n_complete;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bp       <= tle_pkg::BLINK_RESET;
            r_tw       <= tle_pkg::TAB_RESET;
            r_len      <= '0;
            r_rp       <= '0;
            r_complete <= 1'b0;
            r_idle     <= 8'd0;
            r_cursor   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    tle_pkg::CFG_BLINK: r_bp <= i_cfg_data;
                    tle_pkg::CFG_TAB:   r_tw <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_len      <= n_len;
                r_rp       <= n_rp;
                r_complete <= n_complete;
                r_idle     <= n_idle;
                r_cursor   <= n_cursor;
            end
        end
    end

    assign o_load    = accept;
    assign o_burst   = burst;
    assign o_wr_base = r_len[AW-1:0];
    assign o_rd_en   = accept && rd_op;
    assign o_rd_addr = r_rp[AW-1:0];

`ifndef SYNTHESIS
    a_rp_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_complete |-> (r_rp < r_len))
        else $error("read position beyond pending line");
    a_edit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_complete |-> ((r_len <= LIMIT) && (r_rp == '0)))
        else $error("editing line overran the newline slot");
`endif

endmodule

`default_nettype wire

### rtl/tle_emit.sv
// tle_emit: result sequencer, one result per cycle unless stalled, into the
// output register, with line store writes for stored bytes. Depends on tle_pkg.
`default_nettype none

module tle_emit #(
    parameter int BUFFER_BYTES = tle_pkg::BUFFER_BYTES_DEF,
    localparam int AW = $clog2(BUFFER_BYTES)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire tle_pkg::t_burst i_burst,
    input  wire logic [AW-1:0]   i_wr_base,
    input  wire logic [7:0]      i_rd_data,
    output logic                 o_gen_free,
    output logic                 o_wr_en,
    output logic      [AW-1:0]   o_wr_addr,
    output logic      [7:0]      o_wr_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output logic      [1:0]      o_out_kind,
    output logic      [7:0]      o_out_byte,
    output logic                 o_line_ready,
    output logic                 o_last
);

    tle_pkg::t_op                 r_op;
    logic [tle_pkg::CNT_W-1:0]    r_cnt;
    logic [tle_pkg::STEP_W-1:0]   r_step;
    logic [7:0]                   r_data;
    logic [AW-1:0]                r_addr;
    logic                         r_lr;

    logic       r_out_valid;
    logic [1:0] r_kind;
    logic [7:0] r_obyte;
    logic       r_olr;
    logic       r_olast;

    logic       emit_now;
    logic [1:0] e_kind;
    logic [7:0] e_byte;

    assign emit_now   = (r_cnt != '0) && (!r_out_valid || !i_out_stall);
    assign o_gen_free = (r_cnt == '0) ||
                        ((r_cnt == tle_pkg::CNT_W'(1)) && emit_now);

    always_comb begin
        e_kind = tle_pkg::KIND_ECHO;
        e_byte = r_data;
        case (r_op)
            tle_pkg::OP_STORE,
            tle_pkg::OP_TAB:   e_byte = r_data;
            tle_pkg::OP_BKSP:  e_byte = tle_pkg::bksp_byte(r_step);
            tle_pkg::OP_GLYPH: e_byte = (r_step == '0) ? r_data : tle_pkg::CH_BS;
            tle_pkg::OP_READ: begin
                e_kind = tle_pkg::KIND_LINE;
                e_byte = i_rd_data;
            end
            default: begin
                e_kind = tle_pkg::KIND_NONE;
                e_byte = 8'd0;
            end
        endcase
    end

    assign o_wr_en   = emit_now &&
                       ((r_op == tle_pkg::OP_STORE) || (r_op == tle_pkg::OP_TAB));
    assign o_wr_addr = r_addr;
    assign o_wr_data = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op        <= tle_pkg::OP_NONE;
            r_cnt       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit_now) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_load) begin
                r_op   <= i_burst.op;
                r_cnt  <= i_burst.cnt;
                r_step <= '0;
            end else if (emit_now) begin
                r_cnt  <= r_cnt - tle_pkg::CNT_W'(1);
                r_step <= r_step + tle_pkg::STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_burst.data;
            r_addr <= i_wr_base;
            r_lr   <= i_burst.lr;
        end else if (emit_now) begin
            r_addr <= r_addr + AW'(1);
        end
        if (emit_now) begin
            r_kind  <= e_kind;
            r_obyte <= e_byte;
            r_olr   <= r_lr;
            r_olast <= (r_cnt == tle_pkg::CNT_W'(1));
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_kind   = r_kind;
    assign o_out_byte   = r_obyte;
    assign o_line_ready = r_olr;
    assign o_last       = r_olast;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= tle_pkg::CNT_W'(tle_pkg::MAX_RESULTS))
        else $error("result count above burst maximum");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_gen_free)
        else $error("burst loaded over unfinished burst");
    a_none_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_kind == tle_pkg::KIND_NONE))
            |-> ((o_out_byte == 8'd0) && o_last))
        else $error("empty result not a lone zero result");
`endif

endmodule

`default_nettype wire

### rtl/terminal_line_editor.sv
// Terminal line editor, top level.
// Channels (valid/stall): input item {req_type, key_byte}; result item
// {out_kind, out_byte, line_ready, last}. A transfer happens at a clock
// edge with valid high and stall low. Config: i_cfg_we writes index
// i_cfg_index (0 blink_period, 1 tab_width) at the edge, no wait.
// Each item yields 1 to 8 results (backspace 5, blink 2, tab up to 8),
// one per cycle unless the receiver stalls; the input transfer loads the
// burst registers, whose results then pass into the output register. A new
// item is taken in the cycle its predecessor's last result enters the
// output register, so items with one result run at one per cycle unless
// the receiver stalls; an item with more results holds the input until its
// last result is emitted. The result sequencer and single output register
// set this rate. A read fetches the line store's registered read port at transfer.
// Reset (i_rst_n low, synchronous) empties the line, clears blink state and
// loads blink_period 5, tab_width 4; the line store is not cleared.
// While the receiver stalls, the held result stays put and input is
// stalled once the next result is ready behind it.
// Depends on tle_pkg, tle_ctrl, tle_emit, tle_line_mem.
`default_nettype none

module terminal_line_editor #(
    parameter int BUFFER_BYTES = tle_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_req_type,
    input  wire logic [7:0] i_key_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic      [1:0] o_out_kind,
    output logic      [7:0] o_out_byte,
    output logic            o_line_ready,
    output logic            o_last,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    localparam int AW = $clog2(BUFFER_BYTES);

    logic            gen_free;
    logic            load;
    tle_pkg::t_burst burst;
    logic [AW-1:0]   wr_base;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic [7:0]      rd_data;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [7:0]      wr_data;

    tle_ctrl #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_key_byte  (i_key_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_gen_free  (gen_free),
        .o_load      (load),
        .o_burst     (burst),
        .o_wr_base   (wr_base),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr)
    );

    tle_emit #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_burst      (burst),
        .i_wr_base    (wr_base),
        .i_rd_data    (rd_data),
        .o_gen_free   (gen_free),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_kind   (o_out_kind),
        .o_out_byte   (o_out_byte),
        .o_line_ready (o_line_ready),
        .o_last       (o_last)
    );

    tle_line_mem #(
        .DEPTH (BUFFER_BYTES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

endmodule

`default_nettype wire
